### sv/sqt_pkg.sv
// ----------------------------------------------------------------------------
// sqt_pkg: shared types and constants of the sprite quad transform
// Fixed field widths, sine polynomial coefficients, pipeline depth and the
// sine/cosine pair handed from the trig unit to the corner datapath.
// ----------------------------------------------------------------------------
package sqt_pkg;

  // Fixed input field widths
  localparam int ANGLE_W    = 12;
  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 8;

  // Angle resolution: one full turn in ANGLE_STEPS (power of two)
  localparam int ANGLE_STEPS = 4096;

  // Sine format Q1.14, phase of 16 bits per turn
  localparam int FRAC_W      = 14;
  localparam int PHASE_W     = FRAC_W + 2;
  localparam int SINE_W      = FRAC_W + 2;
  localparam int Z_W         = FRAC_W + 1;
  localparam int PHASE_SHIFT = PHASE_W - $clog2(ANGLE_STEPS);

  localparam logic [PHASE_W-1:0] QUARTER = PHASE_W'(1) << FRAC_W;

  // Quarter-wave polynomial coefficients
  localparam int SIN_A = 25736;
  localparam int SIN_B = 10512;
  localparam int SIN_C = 1160;

  // Register stages from request to result
  localparam int SINE_LAT   = 4;
  localparam int PIPE_DEPTH = 9;

  typedef struct packed {
    logic signed [SINE_W-1:0] sin_v;
    logic signed [SINE_W-1:0] cos_v;
  } sqt_trig_t;

endpackage

### sv/sprite_quad_transform.sv
// ----------------------------------------------------------------------------
// sprite_quad_transform: scale and rotate one sprite quad per request
// Throughput: one request per cycle; a held output stalls the whole pipeline.
// Reset clears the stage valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
module sprite_quad_transform import sqt_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] origin_x_i,
  input  logic signed [COORD_WIDTH-1:0] origin_y_i,
  input  logic        [COORD_WIDTH-2:0] size_w_i,
  input  logic        [COORD_WIDTH-2:0] size_h_i,
  input  logic signed [SCALE_W-1:0]     scale_x_i,
  input  logic signed [SCALE_W-1:0]     scale_y_i,
  input  logic        [ANGLE_W-1:0]     angle_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] c1_x_o,
  output logic signed [COORD_WIDTH-1:0] c1_y_o,
  output logic signed [COORD_WIDTH-1:0] c2_x_o,
  output logic signed [COORD_WIDTH-1:0] c2_y_o,
  output logic signed [COORD_WIDTH-1:0] c3_x_o,
  output logic signed [COORD_WIDTH-1:0] c3_y_o,
  output logic signed [COORD_WIDTH-1:0] c4_x_o,
  output logic signed [COORD_WIDTH-1:0] c4_y_o,
  output logic signed [COORD_WIDTH-1:0] box_min_x_o,
  output logic signed [COORD_WIDTH-1:0] box_min_y_o,
  output logic        [COORD_WIDTH-2:0] box_w_o,
  output logic        [COORD_WIDTH-2:0] box_h_o
);

  localparam int CW = COORD_WIDTH;
  localparam int W  = CW + 1;                  // world origin
  localparam int L  = CW + 2;                  // local corner
  localparam int P  = L + SCALE_W;             // scale product
  localparam int S  = P + 1 - SCALE_FRAC;      // scaled corner
  localparam int Q  = S + SINE_W;              // rotation product
  localparam int R  = Q + 3 - FRAC_W;          // rotated corner
  localparam int XW = R + 2;                   // derived fourth corner

  localparam logic signed [P:0]   RND_S = (P + 1)'(1) <<< (SCALE_FRAC - 1);
  localparam logic signed [Q+1:0] RND_R = (Q + 2)'(1) <<< (FRAC_W - 1);

  // Rounded rotation term plus world origin
  function automatic logic signed [R-1:0] rot_sum(input logic signed [Q-1:0] a,
                                                 input logic signed [Q-1:0] b,
                                                 input logic signed [W-1:0] o,
                                                 input logic               sub);
    logic signed [Q+1:0] t;
    t = sub ? ((Q + 2)'(a) - (Q + 2)'(b)) : ((Q + 2)'(a) + (Q + 2)'(b));
    t = t + RND_R;
    return R'(signed'(t[Q+1:FRAC_W])) + R'(o);
  endfunction

  // Clamp to the signed coordinate range
  function automatic logic signed [CW-1:0] sat_c(input logic signed [XW-1:0] v);
    logic fits;
    fits = (v[XW-1:CW-1] == {(XW - CW + 1){v[XW-1]}});
    if (fits) begin
      return v[CW-1:0];
    end else if (v[XW-1]) begin
      return {1'b1, {(CW - 1){1'b0}}};
    end else begin
      return {1'b0, {(CW - 1){1'b1}}};
    end
  endfunction

  function automatic logic signed [CW-1:0] min2(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [CW-1:0] max2(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // --------------------------------------------------------------------------
  // Pipeline control: the whole pipe advances unless a held result blocks it
  // --------------------------------------------------------------------------
  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld_d, vld_q;

  assign adv        = !vld_q[PIPE_DEPTH-1] || !out_stall_i;
  assign in_stall_o = !adv;
  assign vld_d      = {vld_q[PIPE_DEPTH-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // --------------------------------------------------------------------------
  // Sine and cosine, ready alongside stage 4
  // --------------------------------------------------------------------------
  sqt_trig_t trig;

  sqt_sine u_sine (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .angle_i (angle_i),
    .trig_o  (trig)
  );

  // --------------------------------------------------------------------------
  // Stage 1: local corners (x1, y1, x2, y2) and world origin
  // --------------------------------------------------------------------------
  logic signed [L-1:0]       loc_d [4];
  logic signed [L-1:0]       loc_q [4];
  logic signed [W-1:0]       wox_d, woy_d;
  logic signed [W-1:0]       wox_q [SINE_LAT+1];
  logic signed [W-1:0]       woy_q [SINE_LAT+1];
  logic signed [SCALE_W-1:0] sx_q, sy_q;

  assign loc_d[0] = -L'(origin_x_i);
  assign loc_d[1] = -L'(origin_y_i);
  assign loc_d[2] = -L'(origin_x_i) + signed'(L'(size_w_i));
  assign loc_d[3] = -L'(origin_y_i) + signed'(L'(size_h_i));
  assign wox_d    = W'(pos_x_i) + W'(origin_x_i);
  assign woy_d    = W'(pos_y_i) + W'(origin_y_i);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      loc_q    <= loc_d;
      sx_q     <= scale_x_i;
      sy_q     <= scale_y_i;
      wox_q[0] <= wox_d;
      woy_q[0] <= woy_d;
      for (int i = 1; i <= SINE_LAT; i++) begin
        wox_q[i] <= wox_q[i-1];
        woy_q[i] <= woy_q[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 2..5: scale, round, wait for the sine, rotation products
  // --------------------------------------------------------------------------
  logic signed [P-1:0] prod_d [4];
  logic signed [P-1:0] prod_q [4];
  logic signed [P:0]   rtmp   [4];
  logic signed [S-1:0] sc_d   [4];
  logic signed [S-1:0] sc_q   [4];
  logic signed [S-1:0] sd_q   [4];
  logic signed [Q-1:0] pc_d   [4];
  logic signed [Q-1:0] ps_d   [4];
  logic signed [Q-1:0] pc_q   [4];
  logic signed [Q-1:0] ps_q   [4];

  for (genvar k = 0; k < 4; k++) begin : g_axis
    if (k % 2 == 0) begin : g_x
      assign prod_d[k] = P'(loc_q[k]) * P'(sx_q);
    end else begin : g_y
      assign prod_d[k] = P'(loc_q[k]) * P'(sy_q);
    end
    assign rtmp[k] = (P + 1)'(prod_q[k]) + RND_S;
    assign sc_d[k] = rtmp[k][P:SCALE_FRAC];
    assign pc_d[k] = Q'(sd_q[k]) * Q'(trig.cos_v);
    assign ps_d[k] = Q'(sd_q[k]) * Q'(trig.sin_v);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= prod_d;
      sc_q   <= sc_d;
      sd_q   <= sc_q;
      pc_q   <= pc_d;
      ps_q   <= ps_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: rotated corners one to three (x, y pairs)
  // --------------------------------------------------------------------------
  logic signed [R-1:0] cor_d [6];
  logic signed [R-1:0] cor_q [6];

  assign cor_d[0] = rot_sum(pc_q[0], ps_q[1], wox_q[SINE_LAT], 1'b1);
  assign cor_d[1] = rot_sum(pc_q[1], ps_q[0], woy_q[SINE_LAT], 1'b0);
  assign cor_d[2] = rot_sum(pc_q[0], ps_q[3], wox_q[SINE_LAT], 1'b1);
  assign cor_d[3] = rot_sum(pc_q[3], ps_q[0], woy_q[SINE_LAT], 1'b0);
  assign cor_d[4] = rot_sum(pc_q[2], ps_q[3], wox_q[SINE_LAT], 1'b1);
  assign cor_d[5] = rot_sum(pc_q[3], ps_q[2], woy_q[SINE_LAT], 1'b0);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cor_q <= cor_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: derive the fourth corner and saturate all eight coordinates
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] x4w, y4w;
  logic signed [CW-1:0] sat_d [8];
  logic signed [CW-1:0] sat_q [8];

  assign x4w = XW'(cor_q[0]) + XW'(cor_q[4]) - XW'(cor_q[2]);
  assign y4w = XW'(cor_q[5]) - XW'(cor_q[3]) + XW'(cor_q[1]);

  for (genvar k = 0; k < 6; k++) begin : g_sat
    assign sat_d[k] = sat_c(XW'(cor_q[k]));
  end
  assign sat_d[6] = sat_c(x4w);
  assign sat_d[7] = sat_c(y4w);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sat_q <= sat_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: bounding box extremes
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] crn_q [8];
  logic signed [CW-1:0] mnx_d, mxx_d, mny_d, mxy_d;
  logic signed [CW-1:0] mnx_q, mxx_q, mny_q, mxy_q;

  assign mnx_d = min2(min2(sat_q[0], sat_q[2]), min2(sat_q[4], sat_q[6]));
  assign mxx_d = max2(max2(sat_q[0], sat_q[2]), max2(sat_q[4], sat_q[6]));
  assign mny_d = min2(min2(sat_q[1], sat_q[3]), min2(sat_q[5], sat_q[7]));
  assign mxy_d = max2(max2(sat_q[1], sat_q[3]), max2(sat_q[5], sat_q[7]));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      crn_q <= sat_q;
      mnx_q <= mnx_d;
      mxx_q <= mxx_d;
      mny_q <= mny_d;
      mxy_q <= mxy_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: box size with saturation, output register
  // --------------------------------------------------------------------------
  logic signed [CW:0]   dw, dh;
  logic        [CW-2:0] bw_d, bh_d, bw_q, bh_q;
  logic signed [CW-1:0] oc_q [8];
  logic signed [CW-1:0] bmx_q, bmy_q;

  assign dw   = (CW + 1)'(mxx_q) - (CW + 1)'(mnx_q);
  assign dh   = (CW + 1)'(mxy_q) - (CW + 1)'(mny_q);
  assign bw_d = (dw[CW:CW-1] != 2'b00) ? '1 : dw[CW-2:0];
  assign bh_d = (dh[CW:CW-1] != 2'b00) ? '1 : dh[CW-2:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      oc_q  <= crn_q;
      bmx_q <= mnx_q;
      bmy_q <= mny_q;
      bw_q  <= bw_d;
      bh_q  <= bh_d;
    end
  end

  assign out_valid_o = vld_q[PIPE_DEPTH-1];
  assign c1_x_o      = oc_q[0];
  assign c1_y_o      = oc_q[1];
  assign c2_x_o      = oc_q[2];
  assign c2_y_o      = oc_q[3];
  assign c3_x_o      = oc_q[4];
  assign c3_y_o      = oc_q[5];
  assign c4_x_o      = oc_q[6];
  assign c4_y_o      = oc_q[7];
  assign box_min_x_o = bmx_q;
  assign box_min_y_o = bmy_q;
  assign box_w_o     = bw_q;
  assign box_h_o     = bh_q;

endmodule

### sv/sqt_sine.sv
// ----------------------------------------------------------------------------
// sqt_sine: pipelined sine and cosine of the sprite angle
// Two lanes (sine, cosine) each evaluate the quarter-wave polynomial in
// four register stages; one multiply per stage, advanced by adv_i.
// ----------------------------------------------------------------------------
module sqt_sine import sqt_pkg::*; (
  input  logic               clk_i,
  input  logic               adv_i,
  input  logic [ANGLE_W-1:0] angle_i,
  output sqt_trig_t          trig_o
);

  localparam int PW = 2 * Z_W;

  logic [PHASE_W-1:0]       ph [2];
  logic signed [SINE_W-1:0] lane_q [2];

  // Phase of the sine lane and of the cosine lane (a quarter turn ahead)
  assign ph[0] = PHASE_W'(angle_i) << PHASE_SHIFT;
  assign ph[1] = ph[0] + QUARTER;

  for (genvar g = 0; g < 2; g++) begin : g_lane
    logic [Z_W-1:0]    z_d;
    logic [PW-1:0]     zz;
    logic [Z_W-1:0]    z1_q, z2_q, z3_q;
    logic [Z_W-1:0]    sq_d, sq1_q, sq2_q;
    logic              n1_q, n2_q, n3_q;
    logic [PW-1:0]     inner_p;
    logic [Z_W-1:0]    inner_d, inner_q;
    logic [PW-1:0]     poly_p;
    logic [Z_W-1:0]    poly_d, poly_q;
    logic [PW-1:0]     mag_p;
    logic [Z_W-1:0]    mag;
    logic signed [SINE_W-1:0] val_d;

    // Fold the phase into the first quarter, mirrored in odd quadrants
    assign z_d = ph[g][FRAC_W] ?
                 Z_W'(QUARTER - PHASE_W'(ph[g][FRAC_W-1:0])) :
                 Z_W'(ph[g][FRAC_W-1:0]);
    assign zz   = PW'(z_d) * PW'(z_d);
    assign sq_d = Z_W'(zz >> FRAC_W);

    // Inner and outer polynomial terms
    assign inner_p = PW'(sq1_q) * PW'(SIN_C);
    assign inner_d = Z_W'(PW'(SIN_B) - (inner_p >> FRAC_W));
    assign poly_p  = PW'(sq2_q) * PW'(inner_q);
    assign poly_d  = Z_W'(PW'(SIN_A) - (poly_p >> FRAC_W));

    // Final product and sign of the lower half turn
    assign mag_p = PW'(z3_q) * PW'(poly_q);
    assign mag   = Z_W'(mag_p >> FRAC_W);
    assign val_d = n3_q ? -SINE_W'(mag) : SINE_W'(mag);

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        z1_q    <= z_d;
        sq1_q   <= sq_d;
        n1_q    <= ph[g][FRAC_W+1];
        z2_q    <= z1_q;
        sq2_q   <= sq1_q;
        inner_q <= inner_d;
        n2_q    <= n1_q;
        z3_q    <= z2_q;
        poly_q  <= poly_d;
        n3_q    <= n2_q;
        lane_q[g] <= val_d;
      end
    end
  end

  assign trig_o.sin_v = lane_q[0];
  assign trig_o.cos_v = lane_q[1];

endmodule

### sv/sqt_checker.sv
// ----------------------------------------------------------------------------
// sqt_checker: port-level checks of the sprite quad transform
// Watches the handshake and the bounding box against the reported corners.
// ----------------------------------------------------------------------------
module sqt_checker #(
  parameter int COORD_WIDTH = 24
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [COORD_WIDTH-1:0] c1_x_o,
  input logic signed [COORD_WIDTH-1:0] c1_y_o,
  input logic signed [COORD_WIDTH-1:0] c2_x_o,
  input logic signed [COORD_WIDTH-1:0] c2_y_o,
  input logic signed [COORD_WIDTH-1:0] c3_x_o,
  input logic signed [COORD_WIDTH-1:0] c3_y_o,
  input logic signed [COORD_WIDTH-1:0] c4_x_o,
  input logic signed [COORD_WIDTH-1:0] c4_y_o,
  input logic signed [COORD_WIDTH-1:0] box_min_x_o,
  input logic signed [COORD_WIDTH-1:0] box_min_y_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(c1_x_o) && $stable(c1_y_o) &&
      $stable(c3_x_o) && $stable(c4_y_o) && $stable(box_min_x_o))
    else $error("stalled result changed");

  // A free consumer never backs up the request side
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("request stalled while output is free");

  // Box minimum is at or below all corners; its x is one of the corner x values
  a_box_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (box_min_x_o <= c1_x_o) && (box_min_x_o <= c2_x_o) &&
      (box_min_x_o <= c3_x_o) && (box_min_x_o <= c4_x_o) &&
      (box_min_y_o <= c1_y_o) && (box_min_y_o <= c2_y_o) &&
      (box_min_y_o <= c3_y_o) && (box_min_y_o <= c4_y_o) &&
      ((box_min_x_o == c1_x_o) || (box_min_x_o == c2_x_o) ||
       (box_min_x_o == c3_x_o) || (box_min_x_o == c4_x_o)))
    else $error("bounding box minimum inconsistent with corners");

endmodule

bind sprite_quad_transform sqt_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sqt_checker (.*);
